### design/fdf_pkg.sv
package fdf_pkg;

  // Default table sizes.
  localparam int NUM_SOURCES_DEF = 16;
  localparam int SEQ_DEPTH_DEF   = 32;

  // Fixed field widths.
  localparam int ADDR_W  = 16;
  localparam int SEQ_W   = 32;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // Register map.
  localparam logic [PADDR_W-1:0] REG_NODE_ADDR = 2'd0;

  // Header kinds.
  localparam logic KIND_LOCAL = 1'b0;

  typedef enum logic [2:0] {
    ACT_SEND    = 3'd0,
    ACT_LOOP    = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_FWD_SRC = 3'd3,
    ACT_FWD_SEQ = 3'd4,
    ACT_DUP     = 3'd5
  } action_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [SEQ_W-1:0]  seq_num;
  } in_word_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] out_src;
    logic [ADDR_W-1:0] out_dst;
    logic [SEQ_W-1:0]  out_seq;
  } out_word_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_LOOKUP,
    TOP_RESULT
  } top_state_t;

  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_SRC_SCAN,
    WALK_SEQ_CHK,
    WALK_RING_SCAN,
    WALK_RECORD,
    WALK_INSERT
  } walk_state_t;

  // Request from the header control to the table walker.
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] src_addr;
    logic [SEQ_W-1:0]  seq_num;
  } lkp_req_t;

  // Verdict of the table walker.
  typedef struct packed {
    logic    done;
    action_t action;
  } lkp_rsp_t;

endpackage

### design/fdf_ram.sv
module fdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fdf_cmp.sv
module fdf_cmp
  import fdf_pkg::*;
(
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output logic             eq,
  output logic             gt
);

  // Shared equality and magnitude compare for tags and sequence numbers.
  assign eq = (a == b);
  assign gt = (a > b);

endmodule

### design/fdf_seq.sv
module fdf_seq
  import fdf_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  lkp_req_t req,
  output lkp_rsp_t rsp
);

  localparam int SrcW      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PtrW      = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int RingDepth = NUM_SOURCES * SEQ_DEPTH;
  localparam int RingAW    = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int RecW      = 1 + PtrW + SEQ_W + ADDR_W;

  localparam logic [SrcW-1:0] SRC_LAST = SrcW'(NUM_SOURCES - 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(SEQ_DEPTH - 1);
  localparam logic [SrcW:0]   SRC_CNT  = (SrcW + 1)'(NUM_SOURCES);
  localparam logic [PtrW:0]   PTR_CNT  = (PtrW + 1)'(SEQ_DEPTH);

  walk_state_t state, state_next;

  logic [SrcW:0]      scan_idx;
  logic [SrcW-1:0]    src_cmp_idx;
  logic [PtrW:0]      ring_idx;
  logic [PtrW-1:0]    ring_cmp_idx;
  logic               cmp_live;
  logic               free_found;
  logic [SrcW-1:0]    free_idx;
  logic [SrcW-1:0]    hit_idx;
  logic [SEQ_W-1:0]   hit_high;
  logic [PtrW-1:0]    hit_ptr;
  logic               hit_wrap;
  logic [SrcW-1:0]    replace_ptr;
  logic [NUM_SOURCES-1:0] src_valid;

  logic               src_we;
  logic [SrcW-1:0]    src_waddr;
  logic [RecW-1:0]    src_wdata;
  logic [SrcW-1:0]    src_raddr;
  logic [RecW-1:0]    src_rdata;
  logic               ring_we;
  logic [RingAW-1:0]  ring_waddr;
  logic [SEQ_W-1:0]   ring_wdata;
  logic [RingAW-1:0]  ring_raddr;
  logic [SEQ_W-1:0]   ring_rdata;

  logic [ADDR_W-1:0]  rd_tag;
  logic [SEQ_W-1:0]   rd_high;
  logic [PtrW-1:0]    rd_ptr;
  logic               rd_wrap;

  logic [SEQ_W-1:0]   cmp_a;
  logic [SEQ_W-1:0]   cmp_b;
  logic               cmp_eq;
  logic               cmp_gt;

  logic               src_issue;
  logic               tag_hit;
  logic               src_last;
  logic               ring_issue;
  logic               entry_ok;
  logic               ring_match;
  logic               ring_last;
  logic [SrcW-1:0]    ins_slot;

  logic [SrcW-1:0]    wr_slot;
  logic [PtrW-1:0]    wr_ptr;
  logic               wr_wrap;
  logic [PtrW-1:0]    wr_ptr_next;
  logic               wr_wrap_next;
  logic [SEQ_W-1:0]   wr_high;

  // Per-source record: {ring wrapped, ring write pointer, highest sequence, tag}.
  fdf_ram #(
    .WIDTH (RecW),
    .DEPTH (NUM_SOURCES)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  fdf_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (RingDepth)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  fdf_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .gt (cmp_gt)
  );

  assign rd_tag  = src_rdata[ADDR_W-1:0];
  assign rd_high = src_rdata[ADDR_W +: SEQ_W];
  assign rd_ptr  = src_rdata[ADDR_W+SEQ_W +: PtrW];
  assign rd_wrap = src_rdata[RecW-1];

  // Scan status and write data.
  always_comb begin
    src_issue  = (scan_idx < SRC_CNT);
    tag_hit    = cmp_live && src_valid[src_cmp_idx] && cmp_eq;
    src_last   = cmp_live && (src_cmp_idx == SRC_LAST);
    ring_issue = (ring_idx < PTR_CNT);
    // Ring slots below the write pointer hold data until the ring has wrapped once.
    entry_ok   = hit_wrap || (ring_cmp_idx < hit_ptr);
    ring_match = cmp_live && entry_ok && cmp_eq;
    ring_last  = cmp_live && (ring_cmp_idx == PTR_LAST);
    ins_slot   = free_found ? free_idx : replace_ptr;

    wr_ptr_next  = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PtrW'(1);
    wr_wrap_next = wr_wrap | (wr_ptr == PTR_LAST);
    if (state == WALK_INSERT) begin
      wr_high = req.seq_num;
    end else begin
      wr_high = cmp_gt ? req.seq_num : hit_high;
    end

    src_raddr  = scan_idx[SrcW-1:0];
    src_waddr  = wr_slot;
    src_wdata  = {wr_wrap_next, wr_ptr_next, wr_high, req.src_addr};
    ring_raddr = RingAW'(int'(hit_idx) * SEQ_DEPTH + int'(ring_idx[PtrW-1:0]));
    ring_waddr = RingAW'(int'(wr_slot) * SEQ_DEPTH + int'(wr_ptr));
    ring_wdata = req.seq_num;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      WALK_IDLE: begin
        if (req.start) begin
          state_next = WALK_SRC_SCAN;
        end
      end
      WALK_SRC_SCAN: begin
        if (tag_hit) begin
          state_next = WALK_SEQ_CHK;
        end else if (src_last) begin
          state_next = WALK_INSERT;
        end
      end
      WALK_SEQ_CHK: begin
        state_next = cmp_gt ? WALK_RECORD : WALK_RING_SCAN;
      end
      WALK_RING_SCAN: begin
        if (ring_match) begin
          state_next = WALK_IDLE;
        end else if (ring_last) begin
          state_next = WALK_RECORD;
        end
      end
      WALK_RECORD: state_next = WALK_IDLE;
      WALK_INSERT: state_next = WALK_IDLE;
      default:     state_next = WALK_IDLE;
    endcase
  end

  always_comb begin
    cmp_a      = req.seq_num;
    cmp_b      = hit_high;
    src_we     = 1'b0;
    ring_we    = 1'b0;
    wr_slot    = hit_idx;
    wr_ptr     = hit_ptr;
    wr_wrap    = hit_wrap;
    rsp.done   = 1'b0;
    rsp.action = ACT_DUP;
    unique case (state)
      WALK_SRC_SCAN: begin
        cmp_a = {{(SEQ_W - ADDR_W){1'b0}}, rd_tag};
        cmp_b = {{(SEQ_W - ADDR_W){1'b0}}, req.src_addr};
      end
      WALK_RING_SCAN: begin
        cmp_a = ring_rdata;
        cmp_b = req.seq_num;
        if (ring_match) begin
          rsp.done = 1'b1;
        end
      end
      WALK_RECORD: begin
        src_we     = 1'b1;
        ring_we    = 1'b1;
        rsp.done   = 1'b1;
        rsp.action = ACT_FWD_SEQ;
      end
      WALK_INSERT: begin
        wr_slot    = ins_slot;
        wr_ptr     = '0;
        wr_wrap    = 1'b0;
        src_we     = 1'b1;
        ring_we    = 1'b1;
        rsp.done   = 1'b1;
        rsp.action = ACT_FWD_SRC;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= WALK_IDLE;
      src_valid   <= '0;
      replace_ptr <= '0;
      cmp_live    <= 1'b0;
      free_found  <= 1'b0;
      scan_idx    <= '0;
      ring_idx    <= '0;
    end else begin
      state <= state_next;
      case (state)
        WALK_IDLE: begin
          if (req.start) begin
            scan_idx   <= '0;
            cmp_live   <= 1'b0;
            free_found <= 1'b0;
          end
        end
        WALK_SRC_SCAN: begin
          // Read address runs one entry ahead of the compare.
          scan_idx    <= scan_idx + (SrcW + 1)'(src_issue);
          cmp_live    <= src_issue;
          src_cmp_idx <= scan_idx[SrcW-1:0];
          if (cmp_live && !src_valid[src_cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= src_cmp_idx;
          end
          if (tag_hit) begin
            hit_idx  <= src_cmp_idx;
            hit_high <= rd_high;
            hit_ptr  <= rd_ptr;
            hit_wrap <= rd_wrap;
          end
        end
        WALK_SEQ_CHK: begin
          ring_idx <= '0;
          cmp_live <= 1'b0;
        end
        WALK_RING_SCAN: begin
          ring_idx     <= ring_idx + (PtrW + 1)'(ring_issue);
          cmp_live     <= ring_issue;
          ring_cmp_idx <= ring_idx[PtrW-1:0];
        end
        WALK_INSERT: begin
          src_valid[ins_slot] <= 1'b1;
          if (!free_found) begin
            replace_ptr <= (replace_ptr == SRC_LAST) ? '0 : replace_ptr + SrcW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/flood_duplicate_filter.sv
// Channel   Direction  Payload      Handshake
// in        input      in_word_t    in_valid / in_stall
// out       output     out_word_t   out_valid / out_stall
// cfg       input      node address APB (psel, penable, pwrite, paddr, pwdata)
//
// Local, loop and deliver headers skip the table. A header for the source
// table is held for the source scan and the ring scan, which both walk one entry
// per cycle through the single shared comparator. The input stalls until the
// result word of a header is loaded.
// Reset is synchronous and clears the table valid bits, the pointers, the
// sequence counter and the node address; no clearing pass is needed.
// The result word sits in an output register, so a stalled output does not stop
// the next header from being accepted and worked on.
module flood_duplicate_filter
  import fdf_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int SEQ_DEPTH   = SEQ_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_word
);

  top_state_t tstate, tstate_next;

  logic [ADDR_W-1:0] node_address;
  logic [SEQ_W-1:0]  seq_counter;
  logic [ADDR_W-1:0] hdr_src;
  logic [ADDR_W-1:0] hdr_dst;
  logic [SEQ_W-1:0]  hdr_seq;
  action_t           act;

  logic     cfg_wr;
  logic     accept;
  logic     is_local;
  logic     is_loop;
  logic     is_deliver;
  logic     to_table;
  action_t  act_early;
  logic     out_free;
  logic     out_load;
  lkp_req_t req;
  lkp_rsp_t rsp;

  // Configuration port: one register, always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_NODE_ADDR);
  assign prdata = (paddr == REG_NODE_ADDR) ?
                  {{(PDATA_W - ADDR_W){1'b0}}, node_address} : '0;

  // Header classification. A local header takes priority over both, a loop over
  // delivery, and only non-local headers that are neither go on to the source table.
  always_comb begin
    accept     = in_valid && !in_stall;
    is_local   = (in_word.kind == KIND_LOCAL);
    is_loop    = (in_word.src_addr == node_address);
    is_deliver = (in_word.dst_addr == node_address);
    to_table   = !is_local && !is_loop && !is_deliver;
    if (is_local) begin
      act_early = ACT_SEND;
    end else if (is_loop) begin
      act_early = ACT_LOOP;
    end else if (is_deliver) begin
      act_early = ACT_DELIVER;
    end else begin
      act_early = ACT_DUP;
    end
  end

  // The walker reads the held header; it only needs the start pulse on the
  // accept cycle itself.
  assign req = '{start: accept && to_table, src_addr: hdr_src, seq_num: hdr_seq};

  fdf_seq #(
    .NUM_SOURCES (NUM_SOURCES),
    .SEQ_DEPTH   (SEQ_DEPTH)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    tstate_next = tstate;
    unique case (tstate)
      TOP_IDLE: begin
        if (accept) begin
          tstate_next = to_table ? TOP_LOOKUP : TOP_RESULT;
        end
      end
      TOP_LOOKUP: begin
        if (rsp.done) begin
          tstate_next = TOP_RESULT;
        end
      end
      TOP_RESULT: begin
        if (out_free) begin
          tstate_next = TOP_IDLE;
        end
      end
      default: tstate_next = TOP_IDLE;
    endcase
  end

  // A new word may be loaded when the output register is empty or being taken.
  always_comb begin
    in_stall = (tstate != TOP_IDLE);
    out_free = !out_valid || !out_stall;
    out_load = (tstate == TOP_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate       <= TOP_IDLE;
      out_valid    <= 1'b0;
      node_address <= '0;
      seq_counter  <= '0;
    end else begin
      tstate <= tstate_next;
      if (cfg_wr) begin
        node_address <= pwdata[ADDR_W-1:0];
      end
      if (accept) begin
        // Local headers are stamped with this node and the running counter.
        hdr_src <= is_local ? node_address : in_word.src_addr;
        hdr_dst <= in_word.dst_addr;
        hdr_seq <= is_local ? seq_counter : in_word.seq_num;
        act     <= act_early;
        if (is_local) begin
          seq_counter <= seq_counter + SEQ_W'(1);
        end
      end
      if ((tstate == TOP_LOOKUP) && rsp.done) begin
        act <= rsp.action;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_word  <= '{action: act, out_src: hdr_src, out_dst: hdr_dst, out_seq: hdr_seq};
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/fdf_checker.sv
module fdf_checker
  import fdf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input out_word_t          out_word
);

  // A header is still being worked on after it is accepted, so the input stalls right after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was accepted");

  // A fresh result is only produced as the block goes back to taking headers.
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result produced while input still stalled");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

  // No result comes out of reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind flood_duplicate_filter fdf_checker u_fdf_checker (.*);
